/* rtl/vsa_pkg.sv */
// Shared types, field layout and codes for the versioned slot allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package vsa_pkg;

    localparam int MAX_SLOTS          = 1024;
    localparam int INDEX_FIELD_BITS   = 20;
    localparam int TYPE_FIELD_BITS    = 4;
    localparam int ACCESS_FIELD_BITS  = 2;
    localparam int VERSION_FIELD_BITS = 6;

    localparam int HANDLE_BITS  = 32;
    localparam int TYPE_LSB     = INDEX_FIELD_BITS;
    localparam int ACCESS_LSB   = INDEX_FIELD_BITS + TYPE_FIELD_BITS;
    localparam int VERSION_LSB  = INDEX_FIELD_BITS + TYPE_FIELD_BITS + ACCESS_FIELD_BITS;

    localparam int POOLS        = 3;
    localparam int POOL_BITS    = 2;
    localparam int SLOT_BITS    = $clog2(MAX_SLOTS);
    localparam int CNT_BITS     = SLOT_BITS + 1;
    localparam int STACK_WORDS  = POOLS * MAX_SLOTS;
    localparam int STACK_ABITS  = POOL_BITS + SLOT_BITS;
    localparam int ENTRY_BITS   = VERSION_FIELD_BITS + SLOT_BITS;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 11;
    localparam int CAP_BITS      = 11;

    localparam int OUT_SLOT_BITS    = 10;
    localparam int OUT_VERSION_BITS = 6;
    localparam int STATUS_BITS      = 3;

    localparam logic [HANDLE_BITS-1:0] INVALID_HANDLE = '1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_INVALID   = 3'd2,
        ST_RANGE     = 3'd3,
        ST_TYPE      = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SAMPLED_CAP    = 3'd0,
        REG_STOR_IMG_CAP   = 3'd1,
        REG_STOR_BUF_CAP   = 3'd2,
        REG_SAMPLED_TYPE   = 3'd3,
        REG_STOR_IMG_TYPE  = 3'd4,
        REG_STOR_BUF_TYPE  = 3'd5,
        REG_READ_ONLY      = 3'd6,
        REG_READ_WRITE     = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        KIND_FETCH = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic [POOL_BITS-1:0] {
        POOL_SAMPLED  = 2'd0,
        POOL_STOR_IMG = 2'd1,
        POOL_STOR_BUF = 2'd2,
        POOL_NONE     = 2'd3
    } pool_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic rd_en;
        logic commit_direct;
        logic commit_pop;
    } vsa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
        logic out_free;
    } vsa_stat_t;

endpackage

/* rtl/vsa_ctrl.sv */
// Sequencing state machine of the slot allocator: accept, decide, stack read.
// Depends on vsa_pkg for the command and status structs.
module vsa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  vsa_pkg::vsa_stat_t stat,
    output vsa_pkg::vsa_cmd_t  cmd
);
    import vsa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.is_pop) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_READ;
                end else if (stat.out_free) begin
                    cmd.commit_direct = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            S_READ: begin
                if (stat.out_free) begin
                    cmd.commit_pop = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

/* rtl/vsa_dpath.sv */
// Datapath of the slot allocator: configuration registers, per-pool counters,
// the free stack memory and the result register. Depends on vsa_pkg.
module vsa_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [vsa_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
    input  logic [vsa_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                                  in_kind,
    input  logic [vsa_pkg::POOL_BITS-1:0]         in_pool,
    input  logic [vsa_pkg::HANDLE_BITS-1:0]       in_handle,
    input  vsa_pkg::vsa_cmd_t                     cmd,
    output vsa_pkg::vsa_stat_t                    stat,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [vsa_pkg::HANDLE_BITS-1:0]       out_handle,
    output logic [vsa_pkg::OUT_SLOT_BITS-1:0]     out_slot,
    output logic [vsa_pkg::OUT_VERSION_BITS-1:0]  out_version,
    output logic [vsa_pkg::STATUS_BITS-1:0]       out_status
);
    import vsa_pkg::*;

    // Configuration.
    logic [CAP_BITS-1:0]          cap_reg   [POOLS];
    logic [TYPE_FIELD_BITS-1:0]   tcode_reg [POOLS];
    logic [ACCESS_FIELD_BITS-1:0] ro_reg, rw_reg;

    // Pool state.
    logic [CNT_BITS-1:0] cnt_reg   [POOLS];
    logic [CNT_BITS-1:0] fresh_reg [POOLS];

    // Latched item.
    logic                   kind_reg;
    logic [POOL_BITS-1:0]   pool_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    // Free stacks and registered read data.
    logic [ENTRY_BITS-1:0]  stack_mem [STACK_WORDS];
    logic [ENTRY_BITS-1:0]  rd_data_reg;
    logic [POOL_BITS-1:0]   pop_pool_reg;

    // Result register.
    logic                        out_valid_reg;
    logic [HANDLE_BITS-1:0]      out_handle_reg;
    logic [OUT_SLOT_BITS-1:0]    out_slot_reg;
    logic [OUT_VERSION_BITS-1:0] out_version_reg;
    status_t                     out_status_reg;

    function automatic logic [CAP_BITS-1:0] eff_cap(input logic [CAP_BITS-1:0] c);
        return (c > CAP_BITS'(MAX_SLOTS)) ? CAP_BITS'(MAX_SLOTS) : c;
    endfunction

    function automatic logic [HANDLE_BITS-1:0] pack_handle(
        input logic [SLOT_BITS-1:0]          idx,
        input logic [TYPE_FIELD_BITS-1:0]    tc,
        input logic [ACCESS_FIELD_BITS-1:0]  acc,
        input logic [VERSION_FIELD_BITS-1:0] ver
    );
        return {ver, acc, tc, INDEX_FIELD_BITS'(idx)};
    endfunction

    // Decision logic for the latched item.
    logic [INDEX_FIELD_BITS-1:0]   h_index;
    logic [TYPE_FIELD_BITS-1:0]    h_type;
    logic [VERSION_FIELD_BITS-1:0] h_version;
    logic [POOL_BITS-1:0]          sel_p;
    logic                          sel_ok;
    logic [CNT_BITS-1:0]           cnt_sel, fresh_sel, cnt_dec;
    logic [CAP_BITS-1:0]           cap_sel;
    logic [ACCESS_FIELD_BITS-1:0]  acc_sel;
    logic                          is_pop;
    status_t                       d_status;
    logic [HANDLE_BITS-1:0]        d_handle;
    logic                          d_push, d_fresh;

    assign h_index   = handle_reg[INDEX_FIELD_BITS-1:0];
    assign h_type    = handle_reg[TYPE_LSB +: TYPE_FIELD_BITS];
    assign h_version = handle_reg[VERSION_LSB +: VERSION_FIELD_BITS];

    always_comb begin
        if (kind_reg == KIND_FETCH) begin
            sel_p  = (pool_reg == POOL_NONE) ? POOL_SAMPLED : pool_reg;
            sel_ok = (pool_reg != POOL_NONE);
        end else if (tcode_reg[0] == h_type) begin
            sel_p  = POOL_SAMPLED;
            sel_ok = 1'b1;
        end else if (tcode_reg[1] == h_type) begin
            sel_p  = POOL_STOR_IMG;
            sel_ok = 1'b1;
        end else if (tcode_reg[2] == h_type) begin
            sel_p  = POOL_STOR_BUF;
            sel_ok = 1'b1;
        end else begin
            sel_p  = POOL_SAMPLED;
            sel_ok = 1'b0;
        end
    end

    assign cnt_sel   = cnt_reg[sel_p];
    assign fresh_sel = fresh_reg[sel_p];
    assign cap_sel   = eff_cap(cap_reg[sel_p]);
    assign acc_sel   = (sel_p == POOL_SAMPLED) ? ro_reg : rw_reg;
    assign cnt_dec   = cnt_sel - CNT_BITS'(1);
    assign is_pop    = (kind_reg == KIND_FETCH) && sel_ok && (cnt_sel != '0);

    always_comb begin
        d_push   = 1'b0;
        d_fresh  = 1'b0;
        d_status = ST_OK;
        d_handle = handle_reg;
        if (kind_reg == KIND_FETCH) begin
            d_handle = '0;
            if (!sel_ok) begin
                d_status = ST_TYPE;
            end else if (fresh_sel >= CNT_BITS'(cap_sel)) begin
                d_status = ST_EXHAUSTED;
            end else begin
                d_fresh  = 1'b1;
                d_handle = pack_handle(fresh_sel[SLOT_BITS-1:0], tcode_reg[sel_p],
                                       acc_sel, '0);
            end
        end else begin
            if (handle_reg == INVALID_HANDLE) begin
                d_status = ST_INVALID;
            end else if (!sel_ok) begin
                d_status = ST_TYPE;
            end else if (h_index >= INDEX_FIELD_BITS'(cap_sel)) begin
                d_status = ST_RANGE;
            end else if (cnt_sel >= CNT_BITS'(MAX_SLOTS)) begin
                d_status = ST_FULL;
            end else begin
                d_push = 1'b1;
            end
        end
    end

    // Popped entry repacked with the pool's codes and a bumped version.
    logic [HANDLE_BITS-1:0] pop_handle;
    assign pop_handle = pack_handle(rd_data_reg[SLOT_BITS-1:0], tcode_reg[pop_pool_reg],
                                    (pop_pool_reg == POOL_SAMPLED) ? ro_reg : rw_reg,
                                    rd_data_reg[SLOT_BITS +: VERSION_FIELD_BITS]
                                        + VERSION_FIELD_BITS'(1));

    assign stat.is_pop   = is_pop;
    assign stat.out_free = !out_valid_reg || out_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg[0]   <= CAP_BITS'(MAX_SLOTS);
            cap_reg[1]   <= CAP_BITS'(MAX_SLOTS);
            cap_reg[2]   <= CAP_BITS'(MAX_SLOTS);
            tcode_reg[0] <= TYPE_FIELD_BITS'(0);
            tcode_reg[1] <= TYPE_FIELD_BITS'(1);
            tcode_reg[2] <= TYPE_FIELD_BITS'(2);
            ro_reg       <= ACCESS_FIELD_BITS'(0);
            rw_reg       <= ACCESS_FIELD_BITS'(1);
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_SAMPLED_CAP:   cap_reg[0]   <= cfg_wdata[CAP_BITS-1:0];
                REG_STOR_IMG_CAP:  cap_reg[1]   <= cfg_wdata[CAP_BITS-1:0];
                REG_STOR_BUF_CAP:  cap_reg[2]   <= cfg_wdata[CAP_BITS-1:0];
                REG_SAMPLED_TYPE:  tcode_reg[0] <= cfg_wdata[TYPE_FIELD_BITS-1:0];
                REG_STOR_IMG_TYPE: tcode_reg[1] <= cfg_wdata[TYPE_FIELD_BITS-1:0];
                REG_STOR_BUF_TYPE: tcode_reg[2] <= cfg_wdata[TYPE_FIELD_BITS-1:0];
                REG_READ_ONLY:     ro_reg       <= cfg_wdata[ACCESS_FIELD_BITS-1:0];
                REG_READ_WRITE:    rw_reg       <= cfg_wdata[ACCESS_FIELD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Item capture and pop bookkeeping.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg   <= in_kind;
            pool_reg   <= in_pool;
            handle_reg <= in_handle;
        end
        if (cmd.rd_en) begin
            pop_pool_reg <= sel_p;
        end
    end

    // Pool counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < POOLS; i++) begin
                cnt_reg[i]   <= '0;
                fresh_reg[i] <= '0;
            end
        end else begin
            if (cmd.commit_direct && d_push) begin
                cnt_reg[sel_p] <= cnt_sel + CNT_BITS'(1);
            end
            if (cmd.commit_direct && d_fresh) begin
                fresh_reg[sel_p] <= fresh_sel + CNT_BITS'(1);
            end
            if (cmd.commit_pop) begin
                cnt_reg[pop_pool_reg] <= cnt_reg[pop_pool_reg] - CNT_BITS'(1);
            end
        end
    end

    // Free stack memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.commit_direct && d_push) begin
            stack_mem[{sel_p, cnt_sel[SLOT_BITS-1:0]}] <= {h_version,
                                                         h_index[SLOT_BITS-1:0]};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= stack_mem[{sel_p, cnt_dec[SLOT_BITS-1:0]}];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit_direct || cmd.commit_pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_direct) begin
            out_handle_reg  <= d_handle;
            out_slot_reg    <= d_handle[OUT_SLOT_BITS-1:0];
            out_version_reg <= d_handle[VERSION_LSB +: OUT_VERSION_BITS];
            out_status_reg  <= d_status;
        end else if (cmd.commit_pop) begin
            out_handle_reg  <= pop_handle;
            out_slot_reg    <= pop_handle[OUT_SLOT_BITS-1:0];
            out_version_reg <= pop_handle[VERSION_LSB +: OUT_VERSION_BITS];
            out_status_reg  <= ST_OK;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_handle  = out_handle_reg;
    assign out_slot    = out_slot_reg;
    assign out_version = out_version_reg;
    assign out_status  = out_status_reg;

endmodule

/* rtl/versioned_slot_allocator_unit.sv */
// Top level of the versioned slot allocator: stream ports, configuration port,
// controller and datapath. Depends on vsa_pkg, vsa_ctrl and vsa_dpath.
//
// Usage. The block hands out and takes back 32-bit slot handles for three
// pools (sampled image, storage image, storage buffer). Each input item is
// either a fetch from a pool or a free of a handle; each produces exactly one
// result item carrying the handle, its index and version, and a status code.
// Handles are laid out, low to high, as index, type, access and version.
//
// Sequencing. An item is taken in the idle state and decided in the execute
// state. A fetch served from the fresh counter, a free and every error finish
// there. A fetch that reuses a freed handle goes on to the read state for the
// registered read of the free stack memory. The result shows on m_tvalid in
// the cycle after it is committed to the output register. Only one item is
// in flight at a time.
//
// Stalls. Results sit in an output register; while the receiver holds
// m_tready low, the block still takes the next item and finishes it as soon
// as that register empties. Configuration writes are always accepted and are
// meant to be issued only while no item is outstanding.
//
// Reset. A synchronous active-low reset restores the register defaults and
// empties all free stacks and fresh counters at once; the free stack memory
// itself is not cleared and needs no clearing pass.
module versioned_slot_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel. tdata: handle_in[31:0]. tuser: kind[0], pool[2:1].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,
    // Result channel. tdata: handle_out[31:0], slot_index[41:32],
    // version_out[47:42]. tuser: status[2:0].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [2:0]  m_tuser,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [vsa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [vsa_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import vsa_pkg::*;

    vsa_cmd_t  cmd;
    vsa_stat_t stat;

    logic [HANDLE_BITS-1:0]      out_handle;
    logic [OUT_SLOT_BITS-1:0]    out_slot;
    logic [OUT_VERSION_BITS-1:0] out_version;
    logic [STATUS_BITS-1:0]      out_status;

    // Registers can be written in any cycle.
    assign cfg_ready = 1'b1;

    vsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vsa_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_idx     (cfg_index),
        .cfg_wdata   (cfg_data),
        .in_kind     (s_tuser[0]),
        .in_pool     (s_tuser[2:1]),
        .in_handle   (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_handle  (out_handle),
        .out_slot    (out_slot),
        .out_version (out_version),
        .out_status  (out_status)
    );

    assign m_tdata = {out_version, out_slot, out_handle};
    assign m_tuser = out_status;

    // Only one item is worked on at a time, so input is closed right after a take.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item was in flight");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= ST_FULL))
        else $error("undefined status code");

    // An exhausted pool hands out an all-zero result.
    a_exhausted_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_EXHAUSTED)) |-> (m_tdata == '0))
        else $error("exhausted fetch returned a nonzero handle");

    // An invalid-handle report echoes the all-ones handle.
    a_invalid_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_INVALID)) |-> (m_tdata[31:0] == INVALID_HANDLE))
        else $error("invalid status without the invalid handle");

endmodule
